// ----- design/box_blur_3x3_stream_macros.svh -----
// assertion macros shared by the blur datapath
`ifndef BOX_BLUR_3X3_STREAM_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_MACROS_SVH

// same-cycle implication, checked outside reset
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bb3_pkg.sv -----
package bb3_pkg;

    localparam int PIX_W      = 8;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 11;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int IMG_WIDTH_W  = 12;
    localparam int IMG_HEIGHT_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int IMG_WIDTH_RST  = 640;
    localparam int IMG_HEIGHT_RST = 480;
    localparam int DIM_MIN        = 3;

    // window sums and divide by nine via reciprocal
    localparam int COL_SUM_W = 10;
    localparam int SUM_W     = 12;
    localparam int RECIP_W   = 13;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [OUT_ROW_W-1:0] out_row_t;
    typedef logic [OUT_COL_W-1:0] out_col_t;

endpackage

// ----- design/bb3_pix_if.sv -----
interface bb3_pix_if
    import bb3_pkg::*;
();
    logic valid;
    logic ready;
    pix_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- design/bb3_res_if.sv -----
interface bb3_res_if
    import bb3_pkg::*;
();
    logic     valid;
    logic     ready;
    pix_t     blurred_value;
    out_row_t out_row;
    out_col_t out_col;
    logic     frame_last;

    modport source (output valid, output blurred_value, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input blurred_value, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

// ----- design/box_blur_3x3_stream.sv -----
// pipeline: a pixel and its result move through stage 1, stage 2 and the output register
// throughput: one pixel per cycle unless results.ready stalls the output, set by the
// single read and single write per cycle of the combined line memory
// reset: counters, window sums and valid flags clear, width 640, height 480;
// line memory contents are not cleared and carry no valid bits
`include "box_blur_3x3_stream_macros.svh"

module box_blur_3x3_stream
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    bb3_pix_if.sink                pixels,
    bb3_res_if.source              results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // column / row counter widths, clamped dimension widths
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WV_W = (CW + 1 > IMG_WIDTH_W) ? CW + 1 : IMG_WIDTH_W;
    localparam int HV_W = (RW + 1 > IMG_HEIGHT_W) ? RW + 1 : IMG_HEIGHT_W;
    localparam int W_RST = (IMG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_WIDTH_RST;
    localparam int H_RST = (IMG_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMG_HEIGHT_RST;
    localparam int LINE_W = 2 * PIX_W;

    // ------------------------------------------------------------------
    // configuration: dimensions are stored already clamped to 3..max
    // ------------------------------------------------------------------
    logic [CW:0]   width_reg;
    logic [RW:0]   height_reg;
    logic [WV_W-1:0] cfg_w_ext;
    logic [HV_W-1:0] cfg_h_ext;
    logic [CW:0]   width_next;
    logic [RW:0]   height_next;

    assign cfg_w_ext = WV_W'(cfg_data[IMG_WIDTH_W-1:0]);
    assign cfg_h_ext = HV_W'(cfg_data[IMG_HEIGHT_W-1:0]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_w_ext < WV_W'(DIM_MIN))
                        width_next = (CW + 1)'(DIM_MIN);
                    else if (cfg_w_ext > WV_W'(MAX_WIDTH))
                        width_next = (CW + 1)'(MAX_WIDTH);
                    else
                        width_next = (CW + 1)'(cfg_w_ext);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_h_ext < HV_W'(DIM_MIN))
                        height_next = (RW + 1)'(DIM_MIN);
                    else if (cfg_h_ext > HV_W'(MAX_HEIGHT))
                        height_next = (RW + 1)'(MAX_HEIGHT);
                    else
                        height_next = (RW + 1)'(cfg_h_ext);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= (CW + 1)'(W_RST);
            height_reg <= (RW + 1)'(H_RST);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic in_acc;
    logic s1_move;

    assign out_en  = !out_valid_reg || results.ready;
    assign s2_en   = !s2_valid_reg || out_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign in_acc  = pixels.valid && s1_en;
    assign s1_move = s1_valid_reg && s2_en;

    assign pixels.ready = s1_en;

    // ------------------------------------------------------------------
    // position counters, advanced on each accepted transaction
    // ------------------------------------------------------------------
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [CW-1:0] col_cnt_next;
    logic [RW-1:0] row_cnt_next;
    logic          col_end;
    logic          row_end;
    logic          emit;
    logic [CW-1:0] col_m1;
    logic [RW-1:0] row_m1;

    assign col_end = ((CW + 1)'(col_cnt_reg) + (CW + 1)'(1)) >= width_reg;
    assign row_end = ((RW + 1)'(row_cnt_reg) + (RW + 1)'(1)) >= height_reg;
    // centre of a full window exists once two rows and two columns are in
    assign emit    = (row_cnt_reg >= RW'(2)) && (col_cnt_reg >= CW'(2));
    assign col_m1  = col_cnt_reg - CW'(1);
    assign row_m1  = row_cnt_reg - RW'(1);

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_acc)
        begin
            if (col_end)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_end ? '0 : row_cnt_reg + RW'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // line memory: one entry per column holds {two rows above, row above}
    // read when the pixel is accepted, written back when it leaves stage 1;
    // consecutive pixels always hit different columns, so no forwarding
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;
    logic [CW-1:0]     mem_waddr;
    logic [LINE_W-1:0] mem_wdata;
    pix_t              top_px;
    pix_t              mid_px;

    assign top_px = rd_data_reg[LINE_W-1:PIX_W];
    assign mid_px = rd_data_reg[PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s1_move)
            line_mem[mem_waddr] <= mem_wdata;
        if (in_acc)
            rd_data_reg <= line_mem[col_cnt_reg];
    end

    // ------------------------------------------------------------------
    // stage 1: pixel and its position tags wait for the memory read
    // ------------------------------------------------------------------
    pix_t          s1_pix_reg;
    logic [CW-1:0] s1_addr_reg;
    logic          s1_emit_reg;
    out_row_t      s1_row_reg;
    out_col_t      s1_col_reg;
    logic          s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_en)
            s1_valid_reg <= pixels.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg  <= pixels.pixel;
            s1_addr_reg <= col_cnt_reg;
            s1_emit_reg <= emit;
            s1_row_reg  <= OUT_ROW_W'(row_m1);
            s1_col_reg  <= OUT_COL_W'(col_m1);
            s1_last_reg <= row_end && col_end;
        end
    end

    // old column shifts down one row, new pixel becomes the row above
    assign mem_waddr = s1_addr_reg;
    assign mem_wdata = {mid_px, s1_pix_reg};

    // ------------------------------------------------------------------
    // window: running sums of the two previous columns
    // ------------------------------------------------------------------
    logic [COL_SUM_W-1:0] col_prev1_reg;
    logic [COL_SUM_W-1:0] col_prev2_reg;
    logic [COL_SUM_W-1:0] col_cur;
    logic [SUM_W-1:0]     win_sum;

    assign col_cur = COL_SUM_W'(top_px) + COL_SUM_W'(mid_px) + COL_SUM_W'(s1_pix_reg);
    assign win_sum = SUM_W'(col_prev1_reg) + SUM_W'(col_prev2_reg) + SUM_W'(col_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_prev1_reg <= '0;
            col_prev2_reg <= '0;
        end
        else if (s1_move)
        begin
            col_prev2_reg <= col_prev1_reg;
            col_prev1_reg <= col_cur;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: nine-pixel sum for interior pixels only
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] s2_sum_reg;
    out_row_t         s2_row_reg;
    out_col_t         s2_col_reg;
    logic             s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_en)
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_sum_reg  <= win_sum;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register: divide by nine as multiply by 7282 / 2^16, exact
    // for every sum up to 9 * 255
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod;
    pix_t              out_value_reg;
    out_row_t          out_row_reg;
    out_col_t          out_col_reg;
    logic              out_last_reg;

    assign prod = PROD_W'(s2_sum_reg) * PROD_W'(RECIP_9);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && s2_valid_reg)
        begin
            out_value_reg <= prod[RECIP_SHIFT +: PIX_W];
            out_row_reg   <= s2_row_reg;
            out_col_reg   <= s2_col_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.blurred_value = out_value_reg;
    assign results.out_row       = out_row_reg;
    assign results.out_col       = out_col_reg;
    assign results.frame_last    = out_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a held stage-1 transaction keeps its line data
    `BB3_ASSERT_NEXT(a_rd_hold, s1_valid_reg && !s2_en, $stable(rd_data_reg),
        "line read data changed while stage 1 was stalled")
    // write-back never collides with the read of the next transaction
    `BB3_ASSERT_NOW(a_no_rw_clash, s1_move && in_acc, mem_waddr != col_cnt_reg,
        "line memory read and write hit the same column")
    // the last pixel of a frame returns both counters to the origin
    `BB3_ASSERT_NEXT(a_frame_wrap, in_acc && col_end && row_end,
        col_cnt_reg == '0 && row_cnt_reg == '0,
        "counters did not wrap at frame end")
    // a column wrap always resets the column counter
    `BB3_ASSERT_NEXT(a_col_wrap, in_acc && col_end, col_cnt_reg == '0,
        "column counter did not wrap at row end")

endmodule
